FILE: rtl/brcf_pkg.sv
// ----------------------------------------------------------------------------
// brcf_pkg: shared types and constants for the byte ring chunk FIFO
// Item structs, action and status codes, ring geometry and the state type.
// ----------------------------------------------------------------------------
`default_nettype none

package brcf_pkg;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned PTR_W     = ADDR_W + 1;
  localparam int unsigned MAX_CHUNK = 64;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned FILL_W    = 12;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_IDX_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_IDX_W + 1;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [LEN_W-1:0] chunk_length;
    logic             first_of_chunk;
    logic             last_of_chunk;
    logic [7:0]       push_byte;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              has_data;
    logic [7:0]        out_byte;
    logic              last_result;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } brcf_state_t;

endpackage

`default_nettype wire

FILE: rtl/brcf_out_fifo.sv
// ----------------------------------------------------------------------------
// brcf_out_fifo: result queue in front of the output channel
// A small register FIFO that decouples the ring read pipeline from the
// receiver, so reads keep flowing while results wait to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module brcf_out_fifo (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push_valid,
  input  brcf_pkg::out_item_t          push_data,
  output logic [brcf_pkg::OUT_CNT_W-1:0] count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output brcf_pkg::out_item_t          out_data
);
  import brcf_pkg::*;

  out_item_t              entry_r [OUT_DEPTH];
  logic [OUT_IDX_W-1:0]   wr_idx_r;
  logic [OUT_IDX_W-1:0]   rd_idx_r;
  logic [OUT_CNT_W-1:0]   cnt_r;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[rd_idx_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_valid) begin
        wr_idx_r <= wr_idx_r + OUT_IDX_W'(1);
      end
      if (pop) begin
        rd_idx_r <= rd_idx_r + OUT_IDX_W'(1);
      end
      if (push_valid && !pop) begin
        cnt_r <= cnt_r + OUT_CNT_W'(1);
      end else if (pop && !push_valid) begin
        cnt_r <= cnt_r - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_idx_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/byte_ring_chunk_fifo_top.sv
// ----------------------------------------------------------------------------
// byte_ring_chunk_fifo_top: chunked byte ring buffer
// A 4096-byte ring that takes whole chunks or none and returns them on request.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one action per transfer: a push byte, a
//   pop or peek request of up to 64 bytes, or a clear. out_valid/out_ready/
//   out_data carry the results, each with the fill level after the action.
//   A push chunk stays invisible until its last byte commits it.
//   A result passes through the synchronous ring read stage and then the
//   result queue before it appears on the output channel.
//   Push, clear and refused requests are taken back to back while the result
//   queue has space. A pop or peek of N bytes holds the input until its N
//   bytes are read, one ring read per byte through the single read port.
//   Reset: both pointers and any open chunk are cleared; the ring contents
//   are not initialised, since only committed bytes can ever be read.
//   Stall: a four-entry result queue absorbs the receiver's stalls; reads
//   and new transfers pause once the queue and read stage hold four results.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_chunk_fifo_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  brcf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output brcf_pkg::out_item_t  out_data
);
  import brcf_pkg::*;

  // Ring memory.
  logic [7:0]         ring_mem [DEPTH];
  logic [7:0]         mem_q_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_ra;

  // Control state.
  brcf_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   swp_r, swp_nxt;
  logic               refused_r, refused_nxt;
  logic               open_r, open_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LEN_W-1:0]   rd_left_r, rd_left_nxt;
  logic [FILL_W-1:0]  fill_hold_r, fill_hold_nxt;

  // Read stage: one result per cycle while space allows; byte from memory output.
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_status_r, s1_status_nxt;
  logic               s1_has_data_r, s1_has_data_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic [FILL_W-1:0]  s1_fill_r, s1_fill_nxt;

  logic [OUT_CNT_W-1:0] q_count;
  logic               space;
  logic               in_fire;
  out_item_t          s1_item;

  logic [FILL_W-1:0]  fill_cur;
  logic [PTR_W-1:0]   free_cur;
  logic [PTR_W-1:0]   len_ext;
  logic               len_zero;
  logic               len_too_big;

  // Working values for a push item.
  logic               p_open;
  logic               p_ref;
  logic [LEN_W-1:0]   p_left;
  logic [PTR_W-1:0]   p_swp;
  logic [PTR_W-1:0]   p_wp;

  assign fill_cur    = FILL_W'(wp_r - rp_r);
  assign free_cur    = PTR_W'(DEPTH - 1) - PTR_W'(fill_cur);
  assign len_ext     = PTR_W'(in_data.chunk_length);
  assign len_zero    = (in_data.chunk_length == '0);
  assign len_too_big = (in_data.chunk_length > LEN_W'(MAX_CHUNK));

  assign space    = (q_count + OUT_CNT_W'(s1_valid_r)) < OUT_CNT_W'(OUT_DEPTH);
  assign in_ready = (state_r == ST_IDLE) && space;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    rp_nxt          = rp_r;
    wp_nxt          = wp_r;
    swp_nxt         = swp_r;
    refused_nxt     = refused_r;
    open_nxt        = open_r;
    left_nxt        = left_r;
    rd_ptr_nxt      = rd_ptr_r;
    rd_left_nxt     = rd_left_r;
    fill_hold_nxt   = fill_hold_r;
    s1_valid_nxt    = 1'b0;
    s1_status_nxt   = STATUS_OK;
    s1_has_data_nxt = 1'b0;
    s1_last_nxt     = 1'b1;
    s1_fill_nxt     = fill_cur;
    mem_we          = 1'b0;
    mem_wa          = swp_r[ADDR_W-1:0];
    mem_re          = 1'b0;
    mem_ra          = rd_ptr_r[ADDR_W-1:0];
    p_open          = open_r;
    p_ref           = refused_r;
    p_left          = left_r;
    p_swp           = swp_r;
    p_wp            = wp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.action)
            ACT_CLEAR: begin
              rp_nxt       = '0;
              wp_nxt       = '0;
              swp_nxt      = '0;
              refused_nxt  = 1'b0;
              open_nxt     = 1'b0;
              left_nxt     = '0;
              s1_valid_nxt = 1'b1;
              s1_fill_nxt  = '0;
            end
            ACT_PUSH: begin
              if (in_data.first_of_chunk && len_zero) begin
                // An empty chunk is acknowledged at once and opens nothing.
                open_nxt     = 1'b0;
                refused_nxt  = 1'b0;
                left_nxt     = '0;
                swp_nxt      = wp_r;
                s1_valid_nxt = 1'b1;
              end else begin
                if (in_data.first_of_chunk) begin
                  p_open = 1'b1;
                  p_left = in_data.chunk_length;
                  p_swp  = wp_r;
                  p_ref  = len_too_big || (len_ext > free_cur);
                end
                if (p_open) begin
                  if (!p_ref && (p_left != '0)) begin
                    mem_we = 1'b1;
                    mem_wa = p_swp[ADDR_W-1:0];
                    p_swp  = p_swp + PTR_W'(1);
                    p_left = p_left - LEN_W'(1);
                  end
                  if (in_data.last_of_chunk) begin
                    // The chunk commits only if every stated byte arrived.
                    if (!p_ref && (p_left == '0)) begin
                      p_wp          = p_swp;
                      s1_status_nxt = STATUS_OK;
                    end else begin
                      s1_status_nxt = STATUS_REFUSED;
                    end
                    wp_nxt       = p_wp;
                    swp_nxt      = p_wp;
                    open_nxt     = 1'b0;
                    refused_nxt  = 1'b0;
                    left_nxt     = '0;
                    s1_valid_nxt = 1'b1;
                    s1_fill_nxt  = FILL_W'(p_wp - rp_r);
                  end else begin
                    swp_nxt     = p_swp;
                    open_nxt    = p_open;
                    refused_nxt = p_ref;
                    left_nxt    = p_left;
                  end
                end
              end
            end
            ACT_POP, ACT_PEEK: begin
              s1_valid_nxt = 1'b1;
              if (len_zero) begin
                s1_status_nxt = STATUS_OK;
              end else if (len_too_big || (len_ext > PTR_W'(fill_cur))) begin
                s1_status_nxt = STATUS_REFUSED;
              end else begin
                // The first byte is read straight away; the rest follow.
                if (in_data.action == ACT_POP) begin
                  rp_nxt        = rp_r + len_ext;
                  fill_hold_nxt = fill_cur - FILL_W'(in_data.chunk_length);
                end else begin
                  fill_hold_nxt = fill_cur;
                end
                mem_re          = 1'b1;
                mem_ra          = rp_r[ADDR_W-1:0];
                s1_has_data_nxt = 1'b1;
                s1_fill_nxt     = fill_hold_nxt;
                s1_last_nxt     = (in_data.chunk_length == LEN_W'(1));
                rd_ptr_nxt      = rp_r + PTR_W'(1);
                rd_left_nxt     = in_data.chunk_length - LEN_W'(1);
                if (in_data.chunk_length != LEN_W'(1)) begin
                  state_nxt = ST_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (space) begin
          mem_re          = 1'b1;
          mem_ra          = rd_ptr_r[ADDR_W-1:0];
          s1_valid_nxt    = 1'b1;
          s1_has_data_nxt = 1'b1;
          s1_fill_nxt     = fill_hold_r;
          s1_last_nxt     = (rd_left_r == LEN_W'(1));
          rd_ptr_nxt      = rd_ptr_r + PTR_W'(1);
          rd_left_nxt     = rd_left_r - LEN_W'(1);
          if (rd_left_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rp_r       <= '0;
      wp_r       <= '0;
      swp_r      <= '0;
      refused_r  <= 1'b0;
      open_r     <= 1'b0;
      left_r     <= '0;
      rd_ptr_r   <= '0;
      rd_left_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      swp_r      <= swp_nxt;
      refused_r  <= refused_nxt;
      open_r     <= open_nxt;
      left_r     <= left_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      rd_left_r  <= rd_left_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_hold_r   <= fill_hold_nxt;
    s1_status_r   <= s1_status_nxt;
    s1_has_data_r <= s1_has_data_nxt;
    s1_last_r     <= s1_last_nxt;
    s1_fill_r     <= s1_fill_nxt;
  end

  // Pushes only touch entries beyond the write pointer, so a read never
  // meets a write to the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= in_data.push_byte;
    end
    if (mem_re) begin
      mem_q_r <= ring_mem[mem_ra];
    end
  end

  always_comb begin
    s1_item.status      = s1_status_r;
    s1_item.has_data    = s1_has_data_r;
    s1_item.out_byte    = s1_has_data_r ? mem_q_r : 8'd0;
    s1_item.last_result = s1_last_r;
    s1_item.fill_level  = s1_fill_r;
  end

  brcf_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s1_valid_r),
    .push_data  (s1_item),
    .count      (q_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: sim/ring_result_checker.sv
// ----------------------------------------------------------------------------
// ring_result_checker: result prediction and comparison for the chunk FIFO
// Watches both channels of the byte ring. Every input transfer is run through
// a local copy of the ring, which queues the results it should cause. Every
// output transfer is then compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module ring_result_checker (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  wire                         in_ready,
  input  brcf_pkg::in_item_t          in_data,
  input  wire                         out_valid,
  input  wire                         out_ready,
  input  brcf_pkg::out_item_t         out_data,
  output int                          mismatch_count,
  output int                          results_due,
  output logic [brcf_pkg::FILL_W-1:0] ring_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  import brcf_pkg::*;

  logic [7:0]       ring_copy [DEPTH];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] stage_ptr;
  logic             chunk_open;
  logic             chunk_bad;
  int unsigned      chunk_left;
  out_item_t        due_q[$];

  function automatic int unsigned stored_bytes();
    logic [PTR_W-1:0] diff;
    diff = tail_ptr - head_ptr;
    return 32'(diff);
  endfunction

  function automatic out_item_t make_result(logic st, logic hd, logic [7:0] b,
                                            logic lst, int unsigned fill);
    out_item_t r;
    r.status      = st;
    r.has_data    = hd;
    r.out_byte    = b;
    r.last_result = lst;
    r.fill_level  = FILL_W'(fill);
    return r;
  endfunction

  task automatic drop_chunk();
    chunk_open = 1'b0;
    chunk_bad  = 1'b0;
    chunk_left = 0;
  endtask

  task automatic ring_step(input in_item_t it);
    int unsigned      len;
    int unsigned      fill;
    logic [PTR_W-1:0] start;
    logic [PTR_W-1:0] addr;
    logic             st;
    len  = 32'(it.chunk_length);
    fill = stored_bytes();
    case (it.action)
      ACT_CLEAR: begin
        head_ptr  = '0;
        tail_ptr  = '0;
        stage_ptr = '0;
        drop_chunk();
        due_q.push_back(make_result(STATUS_OK, 1'b0, 8'h00, 1'b1, 0));
      end
      ACT_PUSH: begin
        if (it.first_of_chunk && len == 0) begin
          drop_chunk();
          stage_ptr = tail_ptr;
          due_q.push_back(make_result(STATUS_OK, 1'b0, 8'h00, 1'b1, fill));
        end else begin
          // A first byte always opens a fresh chunk, discarding any open one.
          if (it.first_of_chunk) begin
            chunk_open = 1'b1;
            chunk_left = len;
            stage_ptr  = tail_ptr;
            chunk_bad  = (len > MAX_CHUNK) || (len > DEPTH - 1 - fill);
          end
          if (chunk_open) begin
            if (!chunk_bad && chunk_left > 0) begin
              ring_copy[stage_ptr[ADDR_W-1:0]] = it.push_byte;
              stage_ptr  = stage_ptr + 1'b1;
              chunk_left = chunk_left - 1;
            end
            if (it.last_of_chunk) begin
              st = STATUS_REFUSED;
              if (!chunk_bad && chunk_left == 0) begin
                tail_ptr = stage_ptr;
                st       = STATUS_OK;
              end
              stage_ptr = tail_ptr;
              drop_chunk();
              due_q.push_back(make_result(st, 1'b0, 8'h00, 1'b1, stored_bytes()));
            end
          end
        end
      end
      default: begin
        if (len == 0) begin
          due_q.push_back(make_result(STATUS_OK, 1'b0, 8'h00, 1'b1, fill));
        end else if (len > MAX_CHUNK || len > fill) begin
          due_q.push_back(make_result(STATUS_REFUSED, 1'b0, 8'h00, 1'b1, fill));
        end else begin
          start = head_ptr;
          if (it.action == ACT_POP) begin
            head_ptr = head_ptr + PTR_W'(len);
          end
          fill = stored_bytes();
          for (int unsigned i = 0; i < len; i++) begin
            addr = start + PTR_W'(i);
            due_q.push_back(make_result(STATUS_OK, 1'b1, ring_copy[addr[ADDR_W-1:0]],
                                        i + 1 == len, fill));
          end
        end
      end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_q.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result: expected none, actual %p", $time, got);
    end else begin
      want = due_q.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.has_data !== want.has_data)
          $display("%0t: has_data expected %0d actual %0d", $time,
                   want.has_data, got.has_data);
        if (got.out_byte !== want.out_byte)
          $display("%0t: out_byte expected %02h actual %02h", $time,
                   want.out_byte, got.out_byte);
        if (got.last_result !== want.last_result)
          $display("%0t: last_result expected %0d actual %0d", $time,
                   want.last_result, got.last_result);
        if (got.fill_level !== want.fill_level)
          $display("%0t: fill_level expected %0d actual %0d", $time,
                   want.fill_level, got.fill_level);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_ptr       = '0;
      tail_ptr       = '0;
      stage_ptr      = '0;
      drop_chunk();
      due_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        ring_step(in_data);
      end
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
    end
    results_due <= due_q.size();
    ring_fill   <= FILL_W'(stored_bytes());
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the byte ring chunk FIFO
// Runs a short directed pass over the corner cases, then a random mix of
// chunks and requests, with random gaps on both channels and one long
// receiver hold-off part way through the mix.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brcf_pkg::*;

  localparam int IN_W        = $bits(in_item_t);
  localparam int RAND_ITEMS  = 250;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  int                mismatch_count;
  int                results_due;
  logic [FILL_W-1:0] ring_fill;

  int  cycle_count;
  int  sent_count;
  int  tx_quiet;
  int  rx_quiet;
  bit  squeeze_req;
  bit  squeeze_done;

  byte_ring_chunk_fifo_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ring_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .ring_fill      (ring_fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // A random gap per transfer, with occasional runs of back-to-back transfers.
  function automatic int pick_gap(inout int quiet_left);
    int gap;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
    end
    return gap;
  endfunction

  function automatic in_item_t pack_item(logic [1:0] act, int unsigned len,
                                         logic is_first, logic is_last, logic [7:0] b);
    in_item_t it;
    it.action         = act;
    it.chunk_length   = LEN_W'(len);
    it.first_of_chunk = is_first;
    it.last_of_chunk  = is_last;
    it.push_byte      = b;
    return it;
  endfunction

  // Called just after a rising edge; valid is only lowered when a gap follows.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic request(input logic [1:0] act, input int unsigned len);
    send_item(pack_item(act, len, $urandom_range(0, 1), $urandom_range(0, 1), 8'($urandom)));
  endtask

  // Sends a push chunk stating one length but carrying sent bytes; without
  // close the chunk is left open.
  task automatic push_chunk(input int unsigned stated, input int unsigned sent,
                            input bit close);
    for (int unsigned k = 0; k < sent; k++) begin
      send_item(pack_item(ACT_PUSH, (k == 0) ? stated : $urandom_range(0, 127), k == 0,
                          close && (k + 1 == sent), 8'($urandom)));
    end
  endtask

  function automatic int unsigned pick_read_len(int unsigned fill);
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top  = (fill > MAX_CHUNK) ? MAX_CHUNK : fill;
    if (pick < 75 && top > 0) return $urandom_range(1, top);
    if (pick < 85) return 0;
    return $urandom_range(0, 127);
  endfunction

  function automatic int unsigned pick_push_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(1, 8);
    if (pick < 90) return $urandom_range(9, 40);
    return MAX_CHUNK;
  endfunction

  task automatic random_mix();
    int unsigned pick;
    int unsigned len;
    int          start_count;
    start_count = sent_count;
    while (sent_count - start_count < RAND_ITEMS) begin
      // Half way through, the receiver holds off while items keep coming.
      if (sent_count - start_count >= RAND_ITEMS / 2) squeeze_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = pick_push_len();
        push_chunk(len, len, 1'b1);
      end else if (pick < 62) begin
        request(ACT_POP, pick_read_len(32'(ring_fill)));
      end else if (pick < 77) begin
        request(ACT_PEEK, pick_read_len(32'(ring_fill)));
      end else if (pick < 80) begin
        request(ACT_CLEAR, $urandom_range(0, 127));
      end else if (pick < 86) begin
        send_item(in_item_t'(IN_W'($urandom)));
      end else if (pick < 90) begin
        len = $urandom_range(2, 16);
        push_chunk(len, $urandom_range(1, len - 1), 1'b1);
      end else if (pick < 94) begin
        len = $urandom_range(1, 16);
        push_chunk(len, len + $urandom_range(1, 4), 1'b1);
      end else if (pick < 97) begin
        len = $urandom_range(1, 16);
        push_chunk(len, $urandom_range(1, len), 1'b0);
      end else begin
        // A lone middle byte is normally ignored, so it is not counted.
        send_item(pack_item(ACT_PUSH, $urandom_range(0, 127), 1'b0, 1'b0, 8'($urandom)));
        sent_count--;
      end
    end
  endtask

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    sent_count  = 0;
    tx_quiet    = 0;
    squeeze_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Requests against an empty ring, and zero lengths.
    send_item(pack_item(ACT_CLEAR, 0, 1'b0, 1'b0, 8'h00));
    request(ACT_POP, 1);
    request(ACT_PEEK, 0);
    request(ACT_POP, 0);
    send_item(pack_item(ACT_PUSH, 0, 1'b1, 1'b0, 8'h00));
    send_item(pack_item(ACT_PUSH, 5, 1'b0, 1'b1, 8'h11));
    // Single-byte chunk, then chunks that are too long to take.
    send_item(pack_item(ACT_PUSH, 1, 1'b1, 1'b1, 8'hFF));
    send_item(pack_item(ACT_PUSH, 127, 1'b1, 1'b1, 8'hFF));
    send_item(pack_item(ACT_PUSH, 65, 1'b1, 1'b0, 8'h01));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b1, 8'h02));
    request(ACT_PEEK, 1);
    send_item(pack_item(ACT_PUSH, 3, 1'b1, 1'b0, 8'h00));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b0, 8'hA5));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b1, 8'h5A));
    request(ACT_POP, 65);
    request(ACT_PEEK, 5);
    request(ACT_POP, 4);
    // Last byte arrives early, so the chunk is refused.
    send_item(pack_item(ACT_PUSH, 4, 1'b1, 1'b0, 8'h33));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b1, 8'h44));
    // A new first byte restarts the chunk; the bytes past its length are lost.
    send_item(pack_item(ACT_PUSH, 3, 1'b1, 1'b0, 8'h55));
    send_item(pack_item(ACT_PUSH, 2, 1'b1, 1'b0, 8'h66));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b0, 8'h77));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b0, 8'h88));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b1, 8'h99));
    request(ACT_POP, 2);
    // A clear drops the open chunk, so its last byte finds nothing open.
    send_item(pack_item(ACT_PUSH, 5, 1'b1, 1'b0, 8'hC3));
    send_item(pack_item(ACT_CLEAR, 127, 1'b1, 1'b1, 8'hFF));
    send_item(pack_item(ACT_PUSH, 0, 1'b0, 1'b1, 8'h3C));

    random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: a random gap before each result, and one long hold-off so that
  // the result queue fills and the input stalls.
  initial begin
    int gap;
    out_ready    = 1'b0;
    rx_quiet     = 0;
    squeeze_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        gap          = HOLD_CYCLES;
        squeeze_done = 1'b1;
      end else begin
        gap = pick_gap(rx_quiet);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule

FILE: filelist.f
rtl/brcf_pkg.sv
rtl/brcf_out_fifo.sv
rtl/byte_ring_chunk_fifo_top.sv
sim/ring_result_checker.sv
sim/tb_top.sv
